>>> src/pss_pkg.sv
// Shared types, constants and value conversions for the positional sequence store.
// Used by pss_cell and positional_sequence_store_core; depends on nothing.
package pss_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_BACK  = 3'd3;
  localparam logic [2:0] OP_INS_POS   = 3'd4;
  localparam logic [2:0] OP_DISPLAY   = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BADPOS,
    STAT_EMPTY,
    STAT_FULL
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SHOW
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic [DATA_WIDTH-1:0]   data;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]          opcode;
    logic signed [31:0]  value;
    logic [4:0]          position;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [4:0]          occupancy;
    logic signed [31:0]  element;
    logic                last_of_run;
  } out_item_t;

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] to_elem(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           w;
    s = d;
    w = 64'(s);
    return w[31:0];
  endfunction

endpackage

>>> src/pss_cell.sv
// One storage cell of the chain: holds one element and takes data from a neighbor, the command or the head cell.
// Depends on pss_pkg for the cell command type and widths.
module pss_cell (
  input  logic                          clk,
  input  pss_pkg::cell_cmd_t            cmd,
  input  logic [pss_pkg::IDX_W-1:0]     cell_idx,
  input  logic [pss_pkg::DATA_WIDTH-1:0] left_d,
  input  logic [pss_pkg::DATA_WIDTH-1:0] right_d,
  input  logic [pss_pkg::DATA_WIDTH-1:0] head_d,
  output logic [pss_pkg::DATA_WIDTH-1:0] q
);

  logic [pss_pkg::DATA_WIDTH-1:0] data_r;
  logic [pss_pkg::DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      pss_pkg::CELL_INSERT: begin
        if (cell_idx > cmd.idx) begin
          data_nxt = left_d;
        end else if (cell_idx == cmd.idx) begin
          data_nxt = cmd.data;
        end
      end
      pss_pkg::CELL_SHIFT: begin
        data_nxt = right_d;
      end
      pss_pkg::CELL_ROTATE: begin
        if (cell_idx == cmd.idx) begin
          data_nxt = head_d;
        end else if (cell_idx < cmd.idx) begin
          data_nxt = right_d;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

>>> src/positional_sequence_store_core.sv
// Top level of the positional sequence store: sequencer, fill count and chain of cells.
// Depends on pss_pkg and pss_cell.
//
//   channel  ports                        handshake
//   input    start, busy, in_item         beat taken when start && !busy
//   result   out_strobe, out_item         beat shown for one cycle, always taken
//
// An edit beat gives its result in the cycle after acceptance; busy stays low.
// Display holds busy high for the whole run and streams one beat a cycle,
// front to back, by rotating the occupied cells; beats are registered from ST_SHOW.
// Reset clears the fill count, sequencer and strobe; cell contents are not cleared.
// The receiver cannot stall, so results never back up.
module positional_sequence_store_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pss_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output pss_pkg::out_item_t  out_item
);

  localparam int CAP = pss_pkg::CAPACITY;

  pss_pkg::state_t                state_r, state_nxt;
  logic [pss_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [pss_pkg::IDX_W-1:0]      show_idx_r, show_idx_nxt;
  logic                           out_strobe_r, out_strobe_nxt;
  pss_pkg::out_item_t             out_item_r, out_item_nxt;
  pss_pkg::cell_cmd_t             cmd;

  logic [pss_pkg::DATA_WIDTH-1:0] cell_q [CAP];
  logic [pss_pkg::CMP_W-1:0]      pos_ext;
  logic [pss_pkg::CMP_W-1:0]      cnt_ext;
  logic                           full;
  logic                           empty;
  logic [pss_pkg::IDX_W-1:0]      last_idx;

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      pss_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .cell_idx (pss_pkg::IDX_W'(gi)),
        .left_d   ((gi == 0) ? '0 : cell_q[(gi == 0) ? 0 : gi - 1]),
        .right_d  ((gi == CAP - 1) ? '0 : cell_q[(gi == CAP - 1) ? gi : gi + 1]),
        .head_d   (cell_q[0]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  assign pos_ext  = pss_pkg::CMP_W'(in_item.position);
  assign cnt_ext  = pss_pkg::CMP_W'(count_r);
  assign full     = (count_r == pss_pkg::CNT_W'(CAP));
  assign empty    = (count_r == '0);
  assign last_idx = pss_pkg::IDX_W'(count_r - 1'b1);
  assign busy     = (state_r == pss_pkg::ST_SHOW);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    show_idx_nxt   = show_idx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    cmd.op         = pss_pkg::CELL_HOLD;
    cmd.idx        = '0;
    cmd.data       = pss_pkg::to_store(in_item.value);
    case (state_r)
      pss_pkg::ST_IDLE: begin
        if (start) begin
          out_strobe_nxt           = 1'b1;
          out_item_nxt.status      = pss_pkg::STAT_OK;
          out_item_nxt.element     = '0;
          out_item_nxt.last_of_run = 1'b1;
          case (in_item.opcode)
            pss_pkg::OP_INS_FRONT, pss_pkg::OP_INS_BACK: begin
              if (full) begin
                out_item_nxt.status = pss_pkg::STAT_FULL;
              end else begin
                cmd.op    = pss_pkg::CELL_INSERT;
                cmd.idx   = (in_item.opcode == pss_pkg::OP_INS_FRONT) ? '0 :
                            pss_pkg::IDX_W'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            pss_pkg::OP_DEL_FRONT: begin
              if (empty) begin
                out_item_nxt.status = pss_pkg::STAT_EMPTY;
              end else begin
                cmd.op    = pss_pkg::CELL_SHIFT;
                count_nxt = count_r - 1'b1;
              end
            end
            pss_pkg::OP_DEL_BACK: begin
              if (empty) begin
                out_item_nxt.status = pss_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            pss_pkg::OP_INS_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                out_item_nxt.status = pss_pkg::STAT_BADPOS;
              end else if (full) begin
                out_item_nxt.status = pss_pkg::STAT_FULL;
              end else begin
                cmd.op    = pss_pkg::CELL_INSERT;
                cmd.idx   = pss_pkg::IDX_W'(pos_ext - 1'b1);
                count_nxt = count_r + 1'b1;
              end
            end
            pss_pkg::OP_DISPLAY: begin
              if (empty) begin
                out_item_nxt.status = pss_pkg::STAT_EMPTY;
              end else begin
                out_strobe_nxt = 1'b0;
                show_idx_nxt   = '0;
                state_nxt      = pss_pkg::ST_SHOW;
              end
            end
            default: begin
              out_item_nxt.status = pss_pkg::STAT_OK;
            end
          endcase
          out_item_nxt.occupancy = 5'(count_nxt);
        end
      end
      pss_pkg::ST_SHOW: begin
        cmd.op                   = pss_pkg::CELL_ROTATE;
        cmd.idx                  = last_idx;
        out_strobe_nxt           = 1'b1;
        out_item_nxt.status      = pss_pkg::STAT_OK;
        out_item_nxt.occupancy   = 5'(count_r);
        out_item_nxt.element     = pss_pkg::to_elem(cell_q[0]);
        out_item_nxt.last_of_run = (show_idx_r == last_idx);
        if (show_idx_r == last_idx) begin
          state_nxt = pss_pkg::ST_IDLE;
        end else begin
          show_idx_nxt = show_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = pss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pss_pkg::ST_IDLE;
      count_r      <= '0;
      show_idx_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      show_idx_r   <= show_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pss_pkg::CNT_W'(CAP))
    else $error("fill count above capacity");

  a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !empty)
    else $error("display running on an empty store");

  a_show_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("display cycle produced no beat");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last_of_run |-> busy || $past(busy))
    else $error("non-final beat outside a display run");

  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode != pss_pkg::OP_DISPLAY |=>
      out_strobe && out_item.last_of_run)
    else $error("edit beat missing its result");

endmodule

>>> test/tb_positional_sequence_store_core.sv
// Self-checking bench for positional_sequence_store_core: directed and random edit and
// display commands, with results checked beat by beat against an in-bench sequence model.
// Depends on pss_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_positional_sequence_store_core;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_CMDS  = 130;
  localparam int SEGMENT_LEN  = 25;
  localparam int DRAIN_CYCLES = pss_pkg::CAPACITY + 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pss_pkg::in_item_t  in_item = '0;
  logic               out_strobe;
  pss_pkg::out_item_t out_item;

  pss_pkg::in_item_t              cmd_queue[$];
  pss_pkg::out_item_t             due_results[$];
  logic [pss_pkg::DATA_WIDTH-1:0] seq_cells[pss_pkg::CAPACITY];
  int                             seq_fill = 0;
  int                             plan_fill = 0;
  int                             sent_beats = 0;
  int                             taken_beats = 0;
  int                             gap_left = 0;
  int                             burst_left = 0;
  int                             mismatches = 0;
  int                             cycles = 0;

  positional_sequence_store_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one command to the sequence model and queue the beats it yields.
  task automatic apply_sequence_op(input pss_pkg::in_item_t cmd);
    pss_pkg::out_item_t             r;
    logic [pss_pkg::DATA_WIDTH-1:0] word;
    int                             idx;
    r = '0;
    r.status = pss_pkg::STAT_OK;
    r.last_of_run = 1'b1;
    for (int b = 0; b < pss_pkg::DATA_WIDTH; b++)
      word[b] = (b < 32) ? cmd.value[b] : cmd.value[31];
    case (cmd.opcode)
      pss_pkg::OP_INS_FRONT, pss_pkg::OP_INS_BACK, pss_pkg::OP_INS_POS: begin
        if (cmd.opcode == pss_pkg::OP_INS_FRONT) idx = 0;
        else if (cmd.opcode == pss_pkg::OP_INS_BACK) idx = seq_fill;
        else idx = int'(cmd.position) - 1;
        if (cmd.opcode == pss_pkg::OP_INS_POS &&
            (cmd.position == 0 || cmd.position > seq_fill + 1)) begin
          r.status = pss_pkg::STAT_BADPOS;
        end else if (seq_fill >= pss_pkg::CAPACITY) begin
          r.status = pss_pkg::STAT_FULL;
        end else begin
          for (int i = seq_fill; i > idx; i--) seq_cells[i] = seq_cells[i-1];
          seq_cells[idx] = word;
          seq_fill++;
        end
      end
      pss_pkg::OP_DEL_FRONT: begin
        if (seq_fill == 0) begin
          r.status = pss_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i + 1 < seq_fill; i++) seq_cells[i] = seq_cells[i+1];
          seq_fill--;
        end
      end
      pss_pkg::OP_DEL_BACK: begin
        if (seq_fill == 0) r.status = pss_pkg::STAT_EMPTY;
        else seq_fill--;
      end
      pss_pkg::OP_DISPLAY: begin
        if (seq_fill == 0) begin
          r.status = pss_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < seq_fill; i++) begin
            for (int b = 0; b < 32; b++) begin
              r.element[b] = (b < pss_pkg::DATA_WIDTH) ? seq_cells[i][b] :
                             seq_cells[i][pss_pkg::DATA_WIDTH-1];
            end
            r.occupancy = seq_fill[4:0];
            r.last_of_run = (i == seq_fill - 1);
            due_results.push_back(r);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = seq_fill[4:0];
    due_results.push_back(r);
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic signed [31:0] v,
                           input logic [4:0] p);
    pss_pkg::in_item_t c;
    c.opcode = op;
    c.value = v;
    c.position = p;
    cmd_queue.push_back(c);
    case (op)
      pss_pkg::OP_INS_FRONT, pss_pkg::OP_INS_BACK:
        if (plan_fill < pss_pkg::CAPACITY) plan_fill++;
      pss_pkg::OP_INS_POS:
        if (p >= 1 && p <= plan_fill + 1 && plan_fill < pss_pkg::CAPACITY) plan_fill++;
      pss_pkg::OP_DEL_FRONT, pss_pkg::OP_DEL_BACK: if (plan_fill > 0) plan_fill--;
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_insert();
    case ($urandom_range(0, 2))
      0: queue_cmd(pss_pkg::OP_INS_FRONT, pick_value(), 5'($urandom));
      1: queue_cmd(pss_pkg::OP_INS_BACK, pick_value(), 5'($urandom));
      default: queue_cmd(pss_pkg::OP_INS_POS, pick_value(),
                         5'($urandom_range(1, plan_fill + 1)));
    endcase
  endtask

  task automatic queue_noise();
    queue_cmd(3'($urandom_range(0, 7)), pick_value(), 5'($urandom_range(0, 31)));
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (sent_beats == taken_beats) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (cmd_queue.size() > 0) begin
        in_item <= cmd_queue.pop_front();
        start <= 1'b1;
        sent_beats++;
        if (burst_left > 0) begin
          gap_left = 0;
          burst_left--;
        end else begin
          gap_left = $urandom_range(0, 4);
          if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(8, 24);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    pss_pkg::out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_item), 64'(0));
        end else begin
          want = due_results.pop_front();
          if (out_item.status != want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
          if (out_item.occupancy != want.occupancy)
            report_mismatch("occupancy", 64'(out_item.occupancy), 64'(want.occupancy));
          if (out_item.element != want.element)
            report_mismatch("element", 64'(out_item.element), 64'(want.element));
          if (out_item.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", 64'(out_item.last_of_run),
                            64'(want.last_of_run));
        end
      end
      if (start && !busy) begin
        apply_sequence_op(in_item);
        taken_beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int roll;
    queue_cmd(pss_pkg::OP_DISPLAY, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_DEL_FRONT, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_DEL_BACK, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_INS_POS, 32'sh1234_5678, 5'd0);
    queue_cmd(pss_pkg::OP_INS_POS, 32'sh1234_5678, 5'd2);
    queue_cmd(pss_pkg::OP_INS_POS, 32'sh7FFF_FFFF, 5'd1);
    queue_cmd(pss_pkg::OP_DEL_FRONT, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_INS_BACK, 32'sh8000_0000, 5'd31);
    queue_cmd(pss_pkg::OP_DEL_BACK, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_INS_FRONT, -32'sd1, 5'd0);
    queue_cmd(pss_pkg::OP_INS_BACK, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_INS_POS, 32'sh5555_5555, 5'd3);
    queue_cmd(pss_pkg::OP_INS_POS, 32'shAAAA_AAAA, 5'd2);
    queue_cmd(pss_pkg::OP_INS_POS, 32'sh0F0F_0F0F, 5'd31);
    queue_cmd(OP_SPARE_A, 32'sh7FFF_FFFF, 5'd31);
    queue_cmd(OP_SPARE_B, 32'sh8000_0000, 5'd1);
    queue_cmd(pss_pkg::OP_DISPLAY, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_DEL_FRONT, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_DEL_BACK, 32'sh0, 5'd0);
    queue_cmd(pss_pkg::OP_DISPLAY, 32'sh0, 5'd0);

    // grow toward full, churn, then drain toward empty
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(0, 9);
      case ((n / SEGMENT_LEN) % 3)
        0: begin
          if (roll < 7) queue_insert();
          else if (roll == 7) queue_cmd(pss_pkg::OP_DISPLAY, pick_value(), 5'($urandom));
          else if (roll == 8)
            queue_cmd($urandom_range(0, 1) ? pss_pkg::OP_DEL_FRONT : pss_pkg::OP_DEL_BACK,
                      pick_value(), 5'($urandom));
          else queue_noise();
        end
        1: begin
          if (roll < 5) queue_noise();
          else if (roll < 8) queue_insert();
          else queue_cmd(3'($urandom_range(0, 7)), pick_value(), 5'($urandom));
        end
        default: begin
          if (roll < 7)
            queue_cmd($urandom_range(0, 1) ? pss_pkg::OP_DEL_FRONT : pss_pkg::OP_DEL_BACK,
                      pick_value(), 5'($urandom));
          else if (roll == 7) queue_cmd(pss_pkg::OP_DISPLAY, pick_value(), 5'($urandom));
          else if (roll == 8) queue_insert();
          else queue_noise();
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() > 0 || sent_beats != taken_beats || due_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pss_pkg.sv
src/pss_cell.sv
src/positional_sequence_store_core.sv
test/tb_positional_sequence_store_core.sv
